[hw/rtl/ltlc_pkg.sv]
// Shared types, codes and constants of the line trace and lane change unit.
`timescale 1ns / 1ps

package ltlc_pkg;

  localparam int MOTOR_BITS = 18;
  localparam int LEVEL_BITS = 11;
  localparam int PULSE_BITS = 16;
  localparam int MODE_BITS  = 3;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int OUT_BITS    = 2 * PULSE_BITS + MODE_BITS + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [MOTOR_BITS-1:0] motor_t;
  typedef logic signed [LEVEL_BITS-1:0] level_t;
  typedef logic [MODE_BITS-1:0] mode_t;

  localparam mode_t MODE_WAIT  = 3'd0;
  localparam mode_t MODE_SKIP  = 3'd1;
  localparam mode_t MODE_LOST  = 3'd2;
  localparam mode_t MODE_MERGE = 3'd3;
  localparam mode_t MODE_DONE  = 3'd4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DERIV_GAIN  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_RIGHT  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_LEFT   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_MAX   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENTER_THR   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_WIN  = 3'd6;

  localparam logic [15:0] PROP_GAIN_RESET  = 16'd6554;
  localparam logic [23:0] DERIV_GAIN_RESET = 24'd655360;
  localparam logic [9:0]  BASE_RIGHT_RESET = 10'd10;
  localparam logic [9:0]  BASE_LEFT_RESET  = 10'd13;
  localparam logic [15:0] PULSE_MAX_RESET  = 16'd1000;
  localparam logic [9:0]  ENTER_THR_RESET  = 10'd40;
  localparam logic [9:0]  CENTER_WIN_RESET = 10'd20;

  localparam motor_t MOTOR_MAX = 18'sd131071;
  localparam motor_t MOTOR_MIN = -18'sd131072;

  localparam motor_t SPEED_SKIP        = 18'sd13;
  localparam motor_t SPEED_TURN_RIGHT  = 18'sd11;
  localparam motor_t SPEED_TURN_LEFT   = 18'sd50;
  localparam motor_t SPEED_MERGE_RIGHT = 18'sd11;
  localparam motor_t SPEED_MERGE_LEFT  = 18'sd13;

  localparam level_t LEFT_LEVEL_MIN   = 11'sd10;
  localparam level_t CENTER_LEVEL_MIN = 11'sd65;

  typedef struct packed {
    motor_t   motor_left;
    motor_t   motor_right;
    mode_t    mode;
    logic     trace_off;
  } ltlc_state_t;

  typedef struct packed {
    motor_t motor_left;
    motor_t motor_right;
  } ltlc_pd_t;

endpackage

[hw/rtl/ltlc_pd.sv]
// PD line trace: motor values from offset, previous offset and gains.
`timescale 1ns / 1ps

module ltlc_pd import ltlc_pkg::*; #(
  parameter int OFFSET_BITS = 11,
  parameter int FRAC_BITS   = 16
) (
  input  logic signed [OFFSET_BITS-1:0] offset,
  input  logic signed [OFFSET_BITS-1:0] prev_offset,
  input  logic [15:0]                   prop_gain,
  input  logic [23:0]                   deriv_gain,
  input  logic [9:0]                    base_right,
  input  logic [9:0]                    base_left,
  output ltlc_pd_t                      pd
);

  localparam int CP_W = OFFSET_BITS + 17;
  localparam int CD_W = OFFSET_BITS + 26;
  localparam int BW   = FRAC_BITS + 11;
  localparam int SW   = ((CD_W > BW) ? CD_W : BW) + 2;

  logic signed [OFFSET_BITS:0] diff;
  logic signed [CP_W-1:0]      cp;
  logic signed [CD_W-1:0]      cd;
  logic signed [SW-1:0]        cv;
  logic signed [SW-1:0]        base_r_s;
  logic signed [SW-1:0]        base_l_s;
  logic signed [SW-1:0]        sum_r;
  logic signed [SW-1:0]        sum_l;
  logic signed [SW-1:0]        rnd;
  logic signed [SW-1:0]        q_r;
  logic signed [SW-1:0]        q_l;

  function automatic motor_t sat(input logic signed [SW-1:0] v);
    motor_t r;
    if (v > SW'(MOTOR_MAX)) begin
      r = MOTOR_MAX;
    end else if (v < SW'(MOTOR_MIN)) begin
      r = MOTOR_MIN;
    end else begin
      r = v[MOTOR_BITS-1:0];
    end
    return r;
  endfunction

  assign diff = (OFFSET_BITS+1)'(prev_offset) - (OFFSET_BITS+1)'(offset);
  assign cp   = $signed({1'b0, prop_gain}) * offset;
  assign cd   = $signed({1'b0, deriv_gain}) * diff;
  assign cv   = SW'(cp) - SW'(cd);

  assign base_r_s = $signed(SW'({1'b0, base_right})) <<< FRAC_BITS;
  assign base_l_s = $signed(SW'({1'b0, base_left})) <<< FRAC_BITS;
  assign sum_r    = base_r_s - cv;
  assign sum_l    = base_l_s + cv;

  assign rnd = $signed({{(SW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}});
  assign q_r = $signed(sum_r + (sum_r[SW-1] ? rnd : '0)) >>> FRAC_BITS;
  assign q_l = $signed(sum_l + (sum_l[SW-1] ? rnd : '0)) >>> FRAC_BITS;

  assign pd.motor_right = sat(q_r);
  assign pd.motor_left  = sat(q_l);

endmodule

[hw/rtl/ltlc_step.sv]
// Pulse emission and lane change sequence: next state and result of one tick.
`timescale 1ns / 1ps

module ltlc_step import ltlc_pkg::*; #(
  parameter int OFFSET_BITS = 11
) (
  input  logic signed [OFFSET_BITS-1:0] offset,
  input  level_t                        left_level,
  input  level_t                        center_level,
  input  logic [15:0]                   pulse_max,
  input  logic [9:0]                    enter_thr,
  input  logic [9:0]                    center_win,
  input  ltlc_state_t                   state,
  input  ltlc_pd_t                      pd,
  output ltlc_state_t                   state_next,
  output logic [PULSE_BITS-1:0]         left_pulse,
  output logic [PULSE_BITS-1:0]         right_pulse
);

  localparam int CW = ((OFFSET_BITS > 11) ? OFFSET_BITS : 11) + 1;

  logic signed [CW-1:0] off_w;
  logic signed [CW-1:0] thr_w;
  logic signed [CW-1:0] win_w;
  logic                 centred;
  motor_t               pmax;
  motor_t               clamp_l;
  motor_t               clamp_r;
  motor_t               trace_l;
  motor_t               trace_r;

  assign off_w   = CW'(offset);
  assign thr_w   = $signed(CW'({1'b0, enter_thr}));
  assign win_w   = $signed(CW'({1'b0, center_win}));
  assign centred = (off_w >= -win_w) && (off_w <= win_w);

  assign pmax    = $signed({2'b00, pulse_max});
  assign clamp_l = (state.motor_left >= pmax) ? pmax : state.motor_left;
  assign clamp_r = (state.motor_right >= pmax) ? pmax : state.motor_right;

  assign left_pulse  = clamp_l[MOTOR_BITS-1] ? '0 : clamp_l[PULSE_BITS-1:0];
  assign right_pulse = clamp_r[MOTOR_BITS-1] ? '0 : clamp_r[PULSE_BITS-1:0];

  assign trace_l = state.trace_off ? clamp_l : pd.motor_left;
  assign trace_r = state.trace_off ? clamp_r : pd.motor_right;

  always_comb begin
    state_next.motor_left  = trace_l;
    state_next.motor_right = trace_r;
    state_next.mode        = state.mode;
    state_next.trace_off   = state.trace_off;
    case (state.mode)
      MODE_WAIT: begin
        if (off_w >= thr_w) begin
          state_next.mode      = MODE_SKIP;
          state_next.trace_off = 1'b1;
        end
      end
      MODE_SKIP: begin
        state_next.motor_left  = SPEED_SKIP;
        state_next.motor_right = SPEED_SKIP;
        if (centred) begin
          state_next.mode      = MODE_LOST;
          state_next.trace_off = 1'b0;
        end
      end
      MODE_LOST: begin
        if (left_level == '0) begin
          state_next.mode        = MODE_MERGE;
          state_next.trace_off   = 1'b1;
          state_next.motor_left  = SPEED_TURN_LEFT;
          state_next.motor_right = SPEED_TURN_RIGHT;
        end
      end
      MODE_MERGE: begin
        state_next.motor_left  = SPEED_MERGE_LEFT;
        state_next.motor_right = SPEED_MERGE_RIGHT;
        if ((left_level >= LEFT_LEVEL_MIN) && (center_level >= CENTER_LEVEL_MIN) && centred) begin
          state_next.mode      = MODE_DONE;
          state_next.trace_off = 1'b0;
        end
      end
      MODE_DONE: begin
        state_next.motor_left  = SPEED_MERGE_LEFT;
        state_next.motor_right = SPEED_MERGE_RIGHT;
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/line_trace_pd_lane_change_unit.sv]
// Top level: config registers, beat registers, controller state and handshake.
// Path: an input beat is held in the input register, and its result beat in the
// result register, from which it can be taken.
// Throughput: one beat per cycle while the output is not stalled; the tick update
// is one logic pass between the input and result registers, with state fed back.
// Reset (synchronous, active high) clears motor, offset and sequence state,
// empties both beat registers and loads the default register values.
`timescale 1ns / 1ps

module line_trace_pd_lane_change_unit import ltlc_pkg::*; #(
  parameter int OFFSET_BITS = 11,
  parameter int FRAC_BITS   = 16,
  localparam int IN_BITS     = OFFSET_BITS + 2 * LEVEL_BITS,
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // line_offset, left_line_level, center_level, zero pad
  input  logic [IN_TDATA_W-1:0]     s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // left_pulse_us, right_pulse_us, mode, tracing, zero pad
  output logic [OUT_TDATA_W-1:0]    m_tdata
);

  logic [15:0] prop_gain;
  logic [23:0] deriv_gain;
  logic [9:0]  base_right;
  logic [9:0]  base_left;
  logic [15:0] pulse_max;
  logic [9:0]  enter_thr;
  logic [9:0]  center_win;

  logic                          in_valid;
  logic signed [OFFSET_BITS-1:0] in_offset;
  level_t                        in_left_level;
  level_t                        in_center_level;
  logic                          out_valid;
  logic [OUT_BITS-1:0]           out_data;

  ltlc_state_t                   state;
  ltlc_state_t                   state_next;
  logic signed [OFFSET_BITS-1:0] prev_offset;
  ltlc_pd_t                      pd;
  logic [PULSE_BITS-1:0]         left_pulse;
  logic [PULSE_BITS-1:0]         right_pulse;

  logic s_accept;
  logic fire;

  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= PROP_GAIN_RESET;
      deriv_gain <= DERIV_GAIN_RESET;
      base_right <= BASE_RIGHT_RESET;
      base_left  <= BASE_LEFT_RESET;
      pulse_max  <= PULSE_MAX_RESET;
      enter_thr  <= ENTER_THR_RESET;
      center_win <= CENTER_WIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data[15:0];
        REG_DERIV_GAIN: deriv_gain <= cfg_data[23:0];
        REG_BASE_RIGHT: base_right <= cfg_data[9:0];
        REG_BASE_LEFT:  base_left  <= cfg_data[9:0];
        REG_PULSE_MAX:  pulse_max  <= cfg_data[15:0];
        REG_ENTER_THR:  enter_thr  <= cfg_data[9:0];
        REG_CENTER_WIN: center_win <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_offset       <= s_tdata[OFFSET_BITS-1:0];
      in_left_level   <= s_tdata[OFFSET_BITS +: LEVEL_BITS];
      in_center_level <= s_tdata[OFFSET_BITS+LEVEL_BITS +: LEVEL_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {!state_next.trace_off, state_next.mode, right_pulse, left_pulse};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= '{motor_left: '0, motor_right: '0, mode: MODE_WAIT, trace_off: 1'b0};
      prev_offset <= '0;
    end else if (fire) begin
      state <= state_next;
      if (!state.trace_off) begin
        prev_offset <= in_offset;
      end
    end
  end

  ltlc_pd #(
    .OFFSET_BITS(OFFSET_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_pd (
    .offset     (in_offset),
    .prev_offset(prev_offset),
    .prop_gain  (prop_gain),
    .deriv_gain (deriv_gain),
    .base_right (base_right),
    .base_left  (base_left),
    .pd         (pd)
  );

  ltlc_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .offset      (in_offset),
    .left_level  (in_left_level),
    .center_level(in_center_level),
    .pulse_max   (pulse_max),
    .enter_thr   (enter_thr),
    .center_win  (center_win),
    .state       (state),
    .pd          (pd),
    .state_next  (state_next),
    .left_pulse  (left_pulse),
    .right_pulse (right_pulse)
  );

endmodule

[tb/tb_line_trace_pd_lane_change_unit.sv]
// Testbench: PD line trace and lane change unit against a cycle-free tick predictor.
`timescale 1ns / 1ps

module tb_line_trace_pd_lane_change_unit;
  import ltlc_pkg::*;

  localparam int IN_W         = ((3 * LEVEL_BITS + 7) / 8) * 8;
  localparam int FRAC         = 16;
  localparam int LIMIT_CYCLES = 200000;
  localparam int STALL_CYCLES = 300;
  localparam int MAX_REPORTS  = 10;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic                  tracing;
    mode_t                 mode;
    logic [PULSE_BITS-1:0] right_pulse;
    logic [PULSE_BITS-1:0] left_pulse;
  } tick_out_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_W-1:0]           s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]    m_tdata;

  line_trace_pd_lane_change_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor configuration and state
  logic [15:0] kp_q16;
  logic [23:0] kd_q16;
  logic [9:0]  base_r, base_l;
  logic [15:0] pulse_cap;
  logic [9:0]  enter_thr, centre_win;
  motor_t      drive_left, drive_right;
  level_t      last_offset;
  mode_t       lane_mode;
  logic        trace_hold;

  tick_out_t expected_ticks[$];
  tick_out_t want, got;
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        idle_en = 1'b1;
  int        stall_asked = 0;
  int        stall_served = 0;
  int        stall_left = 0;

  function automatic motor_t sat_motor(longint v);
    if (v > longint'(MOTOR_MAX)) return MOTOR_MAX;
    if (v < longint'(MOTOR_MIN)) return MOTOR_MIN;
    return motor_t'(v);
  endfunction

  function automatic motor_t clamp_high(motor_t m);
    if (int'(m) >= int'(pulse_cap)) return motor_t'({2'b00, pulse_cap});
    return m;
  endfunction

  function automatic bit is_centred(level_t off);
    return int'(off) >= -int'(centre_win) && int'(off) <= int'(centre_win);
  endfunction

  function automatic tick_out_t ctrl_tick(level_t off, level_t ll, level_t cl);
    tick_out_t res;
    longint    one, cv, r, l;
    bit        centred;
    one = longint'(1) << FRAC;
    centred = is_centred(off);
    drive_left = clamp_high(drive_left);
    drive_right = clamp_high(drive_right);
    res.left_pulse = (drive_left < 0) ? '0 : drive_left[PULSE_BITS-1:0];
    res.right_pulse = (drive_right < 0) ? '0 : drive_right[PULSE_BITS-1:0];
    if (!trace_hold) begin
      cv = longint'(kp_q16) * longint'(off)
         - longint'(kd_q16) * longint'(int'(last_offset) - int'(off));
      r = longint'(base_r) * one - cv;
      l = longint'(base_l) * one + cv;
      drive_right = sat_motor(r / one);
      drive_left = sat_motor(l / one);
      last_offset = off;
    end
    case (lane_mode)
      MODE_WAIT: begin
        if (int'(off) >= int'(enter_thr)) begin
          lane_mode = MODE_SKIP;
          trace_hold = 1'b1;
        end
      end
      MODE_SKIP: begin
        drive_right = SPEED_SKIP;
        drive_left = SPEED_SKIP;
        if (centred) begin
          trace_hold = 1'b0;
          lane_mode = MODE_LOST;
        end
      end
      MODE_LOST: begin
        if (ll == 0) begin
          lane_mode = MODE_MERGE;
          trace_hold = 1'b1;
          drive_right = SPEED_TURN_RIGHT;
          drive_left = SPEED_TURN_LEFT;
        end
      end
      MODE_MERGE: begin
        drive_right = SPEED_MERGE_RIGHT;
        drive_left = SPEED_MERGE_LEFT;
        if (ll >= LEFT_LEVEL_MIN && cl >= CENTER_LEVEL_MIN && centred) begin
          trace_hold = 1'b0;
          lane_mode = MODE_DONE;
        end
      end
      MODE_DONE: begin
        drive_right = SPEED_MERGE_RIGHT;
        drive_left = SPEED_MERGE_LEFT;
      end
      default: ;
    endcase
    res.mode = lane_mode;
    res.tracing = !trace_hold;
    return res;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random hold-off, plus one long stall on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (stall_served < stall_asked) begin
      stall_served = stall_served + 1;
      stall_left = STALL_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= idle_en ? ($urandom_range(99) >= 17) : 1'b1;
    end
  end

  task automatic report_mismatch(string field, longint exp_v, longint act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_BITS-1:0];
      if (expected_ticks.size() == 0) begin
        report_mismatch("unexpected beat, mode", -1, got.mode);
      end else begin
        want = expected_ticks.pop_front();
        if (got.left_pulse != want.left_pulse)
          report_mismatch("left_pulse_us", want.left_pulse, got.left_pulse);
        if (got.right_pulse != want.right_pulse)
          report_mismatch("right_pulse_us", want.right_pulse, got.right_pulse);
        if (got.mode != want.mode)
          report_mismatch("mode", want.mode, got.mode);
        if (got.tracing != want.tracing)
          report_mismatch("tracing", want.tracing, got.tracing);
      end
    end
  end

  task automatic send_tick(input level_t off, input level_t ll, input level_t cl);
    if (idle_en && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_W - 3 * LEVEL_BITS){1'b0}}, cl, ll, off};
    do @(posedge clk); while (!s_tready);
    expected_ticks.push_back(ctrl_tick(off, ll, cl));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PROP_GAIN:  kp_q16 = data[15:0];
      REG_DERIV_GAIN: kd_q16 = data[23:0];
      REG_BASE_RIGHT: base_r = data[9:0];
      REG_BASE_LEFT:  base_l = data[9:0];
      REG_PULSE_MAX:  pulse_cap = data[15:0];
      REG_ENTER_THR:  enter_thr = data[9:0];
      REG_CENTER_WIN: centre_win = data[9:0];
      default: ;
    endcase
  endtask

  // upper bits above each register width carry junk to exercise masking
  task automatic write_settings(input logic [15:0] kp, input logic [23:0] kd,
                                input logic [9:0] br, input logic [9:0] bl,
                                input logic [15:0] pm, input logic [9:0] thr,
                                input logic [9:0] win);
    write_reg(REG_PROP_GAIN, {8'($urandom), kp});
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_BASE_RIGHT, {14'($urandom), br});
    write_reg(REG_BASE_LEFT, {14'($urandom), bl});
    write_reg(REG_PULSE_MAX, {8'($urandom), pm});
    write_reg(REG_ENTER_THR, {14'($urandom), thr});
    write_reg(REG_CENTER_WIN, {14'($urandom), win});
  endtask

  function automatic level_t any_level();
    return level_t'($urandom);
  endfunction

  function automatic level_t any_offset();
    if ($urandom_range(1)) return level_t'(int'($urandom_range(127)) - 64);
    return any_level();
  endfunction

  // one tick that keeps the sequence in wait mode
  task automatic send_trace_tick();
    level_t off;
    do off = any_offset(); while (int'(off) >= int'(enter_thr));
    send_tick(off, any_level(), any_level());
  endtask

  task automatic test_directed_edges();
    send_tick(0, 0, 0);
    send_tick(-1024, -1024, -1024);
    send_tick(39, 1023, 1023);
    send_tick(-1, 1, -1);
    send_tick(0, 0, 0);
    write_reg(REG_PROP_GAIN, 24'hFFFFFF);
    write_reg(REG_DERIV_GAIN, 24'hFFFFFF);
    send_tick(-1024, 1023, -1024);
    send_tick(39, -1024, 1023);
    send_tick(-1024, 0, 0);
    send_tick(0, 0, 0);
    write_reg(REG_PULSE_MAX, 24'h0);
    send_tick(20, 5, 5);
    send_tick(-20, -5, -5);
    write_reg(REG_NONE, 24'($urandom));
    send_tick(3, 0, 0);
    write_reg(REG_PULSE_MAX, 24'hFFFF);
    send_tick(-1024, 0, 0);
    send_tick(39, 0, 0);
    send_tick(0, 0, 0);
  endtask

  task automatic test_pd_trace();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_settings(PROP_GAIN_RESET, DERIV_GAIN_RESET, BASE_RIGHT_RESET,
                          BASE_LEFT_RESET, PULSE_MAX_RESET, ENTER_THR_RESET,
                          CENTER_WIN_RESET);
        1: write_settings(16'd0, 24'd0, 10'd0, 10'd0, 16'd0, 10'd1023, 10'd0);
        2: write_settings(16'hFFFF, 24'hFFFFFF, 10'd1000, 10'd1000, 16'hFFFF,
                          10'd1023, 10'd1023);
        3: write_settings(16'($urandom_range(0, 16383)), 24'($urandom_range(0, 1 << 20)),
                          10'($urandom_range(0, 1000)), 10'($urandom_range(0, 1000)),
                          16'($urandom_range(0, 2000)), 10'd0,
                          10'($urandom_range(0, 1023)));
        default: write_settings(16'($urandom), 24'($urandom),
                                10'($urandom_range(0, 1000)),
                                10'($urandom_range(0, 1000)), 16'($urandom),
                                10'($urandom_range(0, 1023)),
                                10'($urandom_range(0, 1023)));
      endcase
      idle_en = (phase != 5);
      repeat (65) send_trace_tick();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_input_backpressure();
    write_settings(16'($urandom_range(0, 16383)), 24'($urandom_range(0, 1 << 20)),
                   10'($urandom_range(0, 1000)), 10'($urandom_range(0, 1000)),
                   16'($urandom_range(0, 2000)), 10'($urandom_range(200, 1023)), 10'd20);
    stall_asked++;
    repeat (60) send_trace_tick();
  endtask

  task automatic test_lane_change_sequence();
    level_t off, ll, cl;
    write_settings(16'($urandom_range(0, 16383)), 24'($urandom_range(0, 1 << 20)),
                   10'($urandom_range(0, 1000)), 10'($urandom_range(0, 1000)),
                   16'($urandom_range(0, 2000)), 10'($urandom_range(40, 1000)), 10'd0);
    send_tick(level_t'(int'(enter_thr) + int'($urandom_range(0, 1023 - enter_thr))),
              any_level(), any_level());
    // skip line: hold off-centre, then recentre
    repeat (30) begin
      do off = any_level(); while (is_centred(off));
      send_tick(off, any_level(), any_level());
    end
    send_tick(0, any_level(), any_level());
    // wait for left line lost, tracing under three gain settings
    for (int chunk = 0; chunk < 3; chunk++) begin
      case (chunk)
        0: write_settings(16'($urandom), 24'($urandom), 10'($urandom_range(0, 1000)),
                          10'($urandom_range(0, 1000)), 16'($urandom), enter_thr,
                          centre_win);
        1: write_settings(16'hFFFF, 24'hFFFFFF, 10'($urandom_range(0, 1000)),
                          10'($urandom_range(0, 1000)), 16'($urandom), enter_thr,
                          centre_win);
        default: write_settings(16'($urandom_range(0, 4095)),
                                24'($urandom_range(0, 1 << 18)),
                                10'($urandom_range(0, 1000)),
                                10'($urandom_range(0, 1000)),
                                16'($urandom_range(0, 1500)), enter_thr, centre_win);
      endcase
      repeat (60) begin
        do ll = any_level(); while (ll == 0);
        send_tick(any_offset(), ll, any_level());
      end
    end
    send_tick(any_offset(), 0, any_level());
    // merge: near misses, then the exit beat
    write_reg(REG_CENTER_WIN, 24'd1023);
    repeat (60) begin
      do begin
        ll = $urandom_range(1) ? level_t'($urandom_range(10, 1023)) : any_level();
        cl = $urandom_range(1) ? level_t'($urandom_range(65, 1023)) : any_level();
        off = any_level();
      end while (ll >= LEFT_LEVEL_MIN && cl >= CENTER_LEVEL_MIN && is_centred(off));
      send_tick(off, ll, cl);
    end
    send_tick(level_t'(int'($urandom_range(0, 2046)) - 1023),
              level_t'($urandom_range(10, 1023)), level_t'($urandom_range(65, 1023)));
    repeat (40) send_tick(any_level(), any_level(), any_level());
  endtask

  initial begin
    kp_q16 = PROP_GAIN_RESET;
    kd_q16 = DERIV_GAIN_RESET;
    base_r = BASE_RIGHT_RESET;
    base_l = BASE_LEFT_RESET;
    pulse_cap = PULSE_MAX_RESET;
    enter_thr = ENTER_THR_RESET;
    centre_win = CENTER_WIN_RESET;
    drive_left = '0;
    drive_right = '0;
    last_offset = '0;
    lane_mode = MODE_WAIT;
    trace_hold = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_pd_trace();
    test_input_backpressure();
    test_lane_change_sequence();
    settle();
    if (mismatches == 0 && expected_ticks.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
hw/rtl/ltlc_pkg.sv
hw/rtl/ltlc_pd.sv
hw/rtl/ltlc_step.sv
hw/rtl/line_trace_pd_lane_change_unit.sv
tb/tb_line_trace_pd_lane_change_unit.sv
